### rtl/core/nbg_pkg.sv
// nbg_pkg: shared constants, types and state encoding for the N-body
// gravity accelerator. No dependencies; used by every rtl/core module but nbg_jobq.
`timescale 1ns / 1ps

package nbg_pkg;

  localparam int MAX_BODIES_DEF = 64;
  localparam int COORD_BITS_DEF = 32;

  localparam int MASS_W    = 32;
  localparam int GRAV_W    = 32;
  localparam int SOFT_W    = 16;
  localparam int ACC_W     = 48;
  localparam int IDX_OUT_W = 6;
  localparam int MUL_W     = 64;
  localparam int PROD_W    = 128;
  localparam int APB_W     = 32;
  localparam int PADDR_W   = 3;

  localparam logic [GRAV_W-1:0] GRAV_RESET = 32'h0100_0000;
  localparam logic [SOFT_W-1:0] SOFT_RESET = '0;

  // register index = paddr[PADDR_W-1:2]
  localparam logic [0:0] REG_GRAV = 1'b0;
  localparam logic [0:0] REG_SOFT = 1'b1;

  // exponent bias of the term scaling
  localparam logic signed [9:0] E_BIAS = 10'sd106;

  localparam logic [63:0]        MAG_SAT = 64'h0000_8000_0000_0000;
  localparam logic signed [63:0] ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TGT_RD,
    ST_TGT_CAP,
    ST_SRC_CHK,
    ST_SRC_CAP,
    ST_SQ_GO,
    ST_SQ_WT,
    ST_SQ_EPS,
    ST_NORM,
    ST_SQRT,
    ST_DIV,
    ST_Q2_GO,
    ST_Q2_WT,
    ST_Q3_GO,
    ST_Q3_WT,
    ST_GM_GO,
    ST_GM_WT,
    ST_T_SHR,
    ST_PQ_GO,
    ST_PQ_WT,
    ST_U_SHR,
    ST_V_LD,
    ST_V_SHR,
    ST_AX_GO,
    ST_AX_WT,
    ST_AX_ACC,
    ST_EMIT
  } back_state_t;

endpackage

### rtl/core/direct_nbody_gravity_accel_top.sv
// direct_nbody_gravity_accel_top: softened direct-summation N-body gravity.
// Uses nbg_pkg, nbg_front, nbg_jobq, nbg_back, nbg_mul.
//
// Usage:
//  - Input channel (in_valid / in_stall): one beat per body, Q16.16 position
//    and mass. The beat with in_last_body = 1 is stored too and closes the set;
//    bodies past MAX_BODIES are dropped but a closing beat still starts a pass.
//  - in_stall is high from the closing beat until the last result of that set
//    has been loaded into the output register.
//  - Output channel (out_valid / out_stall): one beat per stored body in load
//    order, Q24.24 acceleration, saturated; out_last_result marks the last.
//    A held out_stall freezes the output register and, once the next result
//    is ready, the pass waits for it.
//  - Processing: one source-target pair at a time through a shared multiplier
//    (four 32x32 partial products), a 31-step square root and a 62-step
//    divider; a new pair starts only once the last one is through. Bodies
//    load while in_stall is low.
//  - Config (APB, pready tied high): grav_constant at 0x0, softening_length at
//    0x4. Write only while no set is in flight.
//  - Reset (synchronous, rst_n low): empties the loader, clears the pass and
//    output valid, restores G = 1.0 and softening = 0. Body stores are not
//    cleared; a pass only reads entries written in its own set.
`timescale 1ns / 1ps

module direct_nbody_gravity_accel_top #(
  parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF,
  parameter int COORD_BITS = nbg_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // body beats
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_BITS-1:0]    in_pos_x,
  input  logic signed [COORD_BITS-1:0]    in_pos_y,
  input  logic signed [COORD_BITS-1:0]    in_pos_z,
  input  logic [nbg_pkg::MASS_W-1:0]      in_body_mass,
  input  logic                            in_last_body,
  // result beats
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [nbg_pkg::ACC_W-1:0] out_acc_x,
  output logic signed [nbg_pkg::ACC_W-1:0] out_acc_y,
  output logic signed [nbg_pkg::ACC_W-1:0] out_acc_z,
  output logic [nbg_pkg::IDX_OUT_W-1:0]   out_body_index,
  output logic                            out_last_result,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nbg_pkg::PADDR_W-1:0]     paddr,
  input  logic [nbg_pkg::APB_W-1:0]       pwdata,
  output logic [nbg_pkg::APB_W-1:0]       prdata,
  output logic                            pready
);

  localparam int IDX_W = $clog2(MAX_BODIES);
  localparam int CNT_W = $clog2(MAX_BODIES + 1);

  logic [nbg_pkg::GRAV_W-1:0] grav_r;
  logic [nbg_pkg::SOFT_W-1:0] soft_r;
  logic                       reg_wr;
  logic [0:0]                 reg_idx;

  logic                       job_push, job_pop, job_valid, pass_done;
  logic [CNT_W-1:0]           job_n_in, job_n_out;
  logic [IDX_W-1:0]           rd_addr;
  logic [COORD_BITS-1:0]      rd_x, rd_y, rd_z;
  logic [nbg_pkg::MASS_W-1:0] rd_m;
  nbg_pkg::mul_req_t          mul_req;
  nbg_pkg::mul_rsp_t          mul_rsp;

  // ---- register file: write on the access phase, reads are immediate
  assign pready  = 1'b1;
  assign reg_idx = paddr[nbg_pkg::PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= nbg_pkg::GRAV_RESET;
      soft_r <= nbg_pkg::SOFT_RESET;
    end else if (reg_wr) begin
      case (reg_idx)
        nbg_pkg::REG_GRAV: grav_r <= pwdata;
        nbg_pkg::REG_SOFT: soft_r <= pwdata[nbg_pkg::SOFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nbg_pkg::REG_GRAV: prdata = grav_r;
      nbg_pkg::REG_SOFT: prdata = nbg_pkg::APB_W'(soft_r);
      default:           prdata = '0;
    endcase
  end

  // ---- front: loads bodies into the stores, hands a job per set
  nbg_front #(
    .MAX_BODIES (MAX_BODIES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_body_mass (in_body_mass),
    .in_last_body (in_last_body),
    .job_push     (job_push),
    .job_n        (job_n_in),
    .pass_done    (pass_done),
    .rd_addr      (rd_addr),
    .rd_x         (rd_x),
    .rd_y         (rd_y),
    .rd_z         (rd_z),
    .rd_m         (rd_m)
  );

  // ---- job queue between loader and pair engine
  nbg_jobq #(
    .W (CNT_W)
  ) u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .din       (job_n_in),
    .pop       (job_pop),
    .dout      (job_n_out),
    .not_empty (job_valid)
  );

  // ---- back: all-pairs pass and result register
  nbg_back #(
    .MAX_BODIES (MAX_BODIES),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .grav            (grav_r),
    .soft_len        (soft_r),
    .job_valid       (job_valid),
    .job_n           (job_n_out),
    .job_pop         (job_pop),
    .rd_addr         (rd_addr),
    .rd_x            (rd_x),
    .rd_y            (rd_y),
    .rd_z            (rd_z),
    .rd_m            (rd_m),
    .pass_done       (pass_done),
    .mul_req         (mul_req),
    .mul_rsp         (mul_rsp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_acc_x       (out_acc_x),
    .out_acc_y       (out_acc_y),
    .out_acc_z       (out_acc_z),
    .out_body_index  (out_body_index),
    .out_last_result (out_last_result)
  );

  // ---- shared multiplier
  nbg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

endmodule

### rtl/core/nbg_mul.sv
// nbg_mul: 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on nbg_pkg (mul_req_t / mul_rsp_t).
`timescale 1ns / 1ps

module nbg_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  nbg_pkg::mul_req_t req,
  output nbg_pkg::mul_rsp_t rsp
);

  logic [nbg_pkg::MUL_W-1:0]  a_r, b_r;
  logic [nbg_pkg::MUL_W-1:0]  pp_r;
  logic [nbg_pkg::PROD_W-1:0] acc_r;
  logic [nbg_pkg::PROD_W-1:0] pp_ext;
  logic [31:0]                pa, pb;
  logic [2:0]                 step_r;
  logic                       run_r, done_r;

  // step 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
  always_comb begin
    case (step_r)
      3'd1:    begin pa = a_r[31:0];  pb = b_r[63:32]; end
      3'd2:    begin pa = a_r[63:32]; pb = b_r[31:0];  end
      3'd3:    begin pa = a_r[63:32]; pb = b_r[63:32]; end
      default: begin pa = a_r[31:0];  pb = b_r[31:0];  end
    endcase
  end

  // partial product of the previous step, placed at its weight
  always_comb begin
    case (step_r)
      3'd2, 3'd3: pp_ext = {32'd0, pp_r, 32'd0};
      3'd4:       pp_ext = {pp_r, 64'd0};
      default:    pp_ext = {64'd0, pp_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd4) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (run_r) begin
      if (step_r != 3'd4) pp_r <= pa * pb;
      if (step_r != 3'd0) acc_r <= acc_r + pp_ext;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

### rtl/core/nbg_jobq.sv
// nbg_jobq: two-entry queue of pass jobs (body count) from front to back.
// Depends on nothing but its width parameter.
`timescale 1ns / 1ps

module nbg_jobq #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         not_empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign do_push   = push && (cnt_r != 2'd2);
  assign do_pop    = pop && (cnt_r != 2'd0);
  assign not_empty = (cnt_r != 2'd0);
  assign dout      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

### rtl/core/nbg_front.sv
// nbg_front: body loader. Stores positions and masses, counts the set and
// queues a pass job on the last body. Depends on nbg_pkg.
`timescale 1ns / 1ps

module nbg_front #(
  parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF,
  parameter int COORD_BITS = nbg_pkg::COORD_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_BODIES),
  localparam int CNT_W = $clog2(MAX_BODIES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [COORD_BITS-1:0]     in_pos_x,
  input  logic [COORD_BITS-1:0]     in_pos_y,
  input  logic [COORD_BITS-1:0]     in_pos_z,
  input  logic [nbg_pkg::MASS_W-1:0] in_body_mass,
  input  logic                      in_last_body,
  output logic                      job_push,
  output logic [CNT_W-1:0]          job_n,
  input  logic                      pass_done,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [COORD_BITS-1:0]     rd_x,
  output logic [COORD_BITS-1:0]     rd_y,
  output logic [COORD_BITS-1:0]     rd_z,
  output logic [nbg_pkg::MASS_W-1:0] rd_m
);

  logic [COORD_BITS-1:0]      x_mem [MAX_BODIES];
  logic [COORD_BITS-1:0]      y_mem [MAX_BODIES];
  logic [COORD_BITS-1:0]      z_mem [MAX_BODIES];
  logic [nbg_pkg::MASS_W-1:0] m_mem [MAX_BODIES];

  logic [CNT_W-1:0] count_r;
  logic             busy_r;
  logic             accept, room;

  // stores stay frozen while a pass is pending or running
  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign room     = (count_r < CNT_W'(MAX_BODIES));
  assign job_push = accept && in_last_body;
  assign job_n    = room ? count_r + CNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last_body) begin
          count_r <= '0;
          busy_r  <= 1'b1;
        end else if (room) begin
          count_r <= count_r + CNT_W'(1);
        end
      end else if (pass_done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      x_mem[count_r[IDX_W-1:0]] <= in_pos_x;
      y_mem[count_r[IDX_W-1:0]] <= in_pos_y;
      z_mem[count_r[IDX_W-1:0]] <= in_pos_z;
      m_mem[count_r[IDX_W-1:0]] <= in_body_mass;
    end
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
    rd_z <= z_mem[rd_addr];
    rd_m <= m_mem[rd_addr];
  end

endmodule

### rtl/core/nbg_back.sv
// nbg_back: pair sequencer and interaction datapath (normalize, bit-serial
// square root and divide, shared multiplier, saturating sums, result register).
// Depends on nbg_pkg; drives nbg_mul through mul_req_t.
`timescale 1ns / 1ps

module nbg_back #(
  parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF,
  parameter int COORD_BITS = nbg_pkg::COORD_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_BODIES),
  localparam int CNT_W = $clog2(MAX_BODIES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [nbg_pkg::GRAV_W-1:0]    grav,
  input  logic [nbg_pkg::SOFT_W-1:0]    soft_len,
  input  logic                          job_valid,
  input  logic [CNT_W-1:0]              job_n,
  output logic                          job_pop,
  output logic [IDX_W-1:0]              rd_addr,
  input  logic [COORD_BITS-1:0]         rd_x,
  input  logic [COORD_BITS-1:0]         rd_y,
  input  logic [COORD_BITS-1:0]         rd_z,
  input  logic [nbg_pkg::MASS_W-1:0]    rd_m,
  output logic                          pass_done,
  output nbg_pkg::mul_req_t             mul_req,
  input  nbg_pkg::mul_rsp_t             mul_rsp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [nbg_pkg::ACC_W-1:0] out_acc_x,
  output logic signed [nbg_pkg::ACC_W-1:0] out_acc_y,
  output logic signed [nbg_pkg::ACC_W-1:0] out_acc_z,
  output logic [nbg_pkg::IDX_OUT_W-1:0] out_body_index,
  output logic                          out_last_result
);

  nbg_pkg::back_state_t state_r, state_nxt;

  logic [CNT_W-1:0]                n_r, i_r, j_r;
  logic [COORD_BITS-1:0]           tx_r, ty_r, tz_r;
  logic signed [COORD_BITS:0]      d_r [3];
  logic signed [nbg_pkg::ACC_W-1:0] acc_r [3];
  logic [nbg_pkg::MASS_W-1:0]      m_r;
  logic [1:0]                      axis_r;
  logic [nbg_pkg::PROD_W-1:0]      r2_r;
  logic signed [7:0]               k_r;
  logic [63:0]                     sq_n_r, sq_res_r, sq_bit_r;
  logic [31:0]                     rem_r, q_r, q2_r, q3_r, sm_r;
  logic [5:0]                      div_cnt_r;
  logic [63:0]                     sh_r;
  logic [5:0]                      sh_cnt_r, t_r;
  logic signed [9:0]               e_r;
  logic [31:0]                     eps2_r;
  logic signed [63:0]              term_r;

  logic signed [COORD_BITS:0] d_sel;
  logic [COORD_BITS:0]        dmag;
  logic                       out_free, last_tgt, r2_zero, r2_ok;
  logic [63:0]                sq_try;
  logic [32:0]                rem_sh;
  logic [31:0]                root;
  logic signed [9:0]          kh, e_nxt, es, nes;
  logic [63:0]                mag, smag;
  logic signed [63:0]         term_nxt, sum;
  logic signed [nbg_pkg::ACC_W-1:0] sum_sat;

  assign d_sel    = d_r[axis_r];
  assign dmag     = d_sel[COORD_BITS] ? (COORD_BITS + 1)'(-d_sel) : d_sel;
  assign out_free = !out_valid || !out_stall;
  assign last_tgt = ((i_r + CNT_W'(1)) == n_r);
  assign r2_zero  = (r2_r == '0);
  assign r2_ok    = (r2_r[127:62] == '0) && (r2_r[61:60] != 2'b00);
  assign sq_try   = sq_res_r + sq_bit_r;
  assign root     = sq_res_r[31:0];
  assign rem_sh   = {rem_r, 1'b1};

  // exponent of the term scale: t + u - 106 - 3*(k/2); k is always even
  assign kh    = {{3{k_r[7]}}, k_r[7:1]};
  assign e_nxt = $signed({4'd0, t_r}) + $signed({4'd0, sh_cnt_r}) - nbg_pkg::E_BIAS
                 - (kh + (kh <<< 1));

  // scaled term magnitude, signed by the axis difference
  assign mag = mul_rsp.prod[63:0];
  assign es  = e_r + $signed({4'd0, sh_cnt_r});
  assign nes = -es;
  always_comb begin
    if (!es[9]) begin
      if (mag == '0)                                   smag = '0;
      else if (es >= 10'sd64)                          smag = nbg_pkg::MAG_SAT;
      else if (mag > (nbg_pkg::MAG_SAT >> es[5:0]))    smag = nbg_pkg::MAG_SAT;
      else                                             smag = mag << es[5:0];
    end else begin
      if (nes >= 10'sd64) smag = '0;
      else                smag = mag >> nes[5:0];
    end
    term_nxt = d_sel[COORD_BITS] ? -$signed(smag) : $signed(smag);
  end

  assign sum = {{(64 - nbg_pkg::ACC_W){acc_r[axis_r][nbg_pkg::ACC_W-1]}}, acc_r[axis_r]}
               + term_r;
  always_comb begin
    if (sum > nbg_pkg::ACC_MAX)      sum_sat = nbg_pkg::ACC_MAX[nbg_pkg::ACC_W-1:0];
    else if (sum < nbg_pkg::ACC_MIN) sum_sat = nbg_pkg::ACC_MIN[nbg_pkg::ACC_W-1:0];
    else                             sum_sat = sum[nbg_pkg::ACC_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nbg_pkg::ST_IDLE:    if (job_valid) state_nxt = nbg_pkg::ST_TGT_RD;
      nbg_pkg::ST_TGT_RD:  state_nxt = nbg_pkg::ST_TGT_CAP;
      nbg_pkg::ST_TGT_CAP: state_nxt = nbg_pkg::ST_SRC_CHK;
      nbg_pkg::ST_SRC_CHK: begin
        if (j_r == n_r)      state_nxt = nbg_pkg::ST_EMIT;
        else if (j_r != i_r) state_nxt = nbg_pkg::ST_SRC_CAP;
      end
      nbg_pkg::ST_SRC_CAP: state_nxt = nbg_pkg::ST_SQ_GO;
      nbg_pkg::ST_SQ_GO:   state_nxt = nbg_pkg::ST_SQ_WT;
      nbg_pkg::ST_SQ_WT: begin
        if (mul_rsp.done)
          state_nxt = (axis_r == 2'd2) ? nbg_pkg::ST_SQ_EPS : nbg_pkg::ST_SQ_GO;
      end
      nbg_pkg::ST_SQ_EPS:  state_nxt = nbg_pkg::ST_NORM;
      nbg_pkg::ST_NORM: begin
        if (r2_zero)    state_nxt = nbg_pkg::ST_SRC_CHK;
        else if (r2_ok) state_nxt = nbg_pkg::ST_SQRT;
      end
      nbg_pkg::ST_SQRT:    if (sq_bit_r == '0) state_nxt = nbg_pkg::ST_DIV;
      nbg_pkg::ST_DIV:     if (div_cnt_r == 6'd61) state_nxt = nbg_pkg::ST_Q2_GO;
      nbg_pkg::ST_Q2_GO:   state_nxt = nbg_pkg::ST_Q2_WT;
      nbg_pkg::ST_Q2_WT:   if (mul_rsp.done) state_nxt = nbg_pkg::ST_Q3_GO;
      nbg_pkg::ST_Q3_GO:   state_nxt = nbg_pkg::ST_Q3_WT;
      nbg_pkg::ST_Q3_WT:   if (mul_rsp.done) state_nxt = nbg_pkg::ST_GM_GO;
      nbg_pkg::ST_GM_GO:   state_nxt = nbg_pkg::ST_GM_WT;
      nbg_pkg::ST_GM_WT:   if (mul_rsp.done) state_nxt = nbg_pkg::ST_T_SHR;
      nbg_pkg::ST_T_SHR:   if (sh_r[63:32] == '0) state_nxt = nbg_pkg::ST_PQ_GO;
      nbg_pkg::ST_PQ_GO:   state_nxt = nbg_pkg::ST_PQ_WT;
      nbg_pkg::ST_PQ_WT:   if (mul_rsp.done) state_nxt = nbg_pkg::ST_U_SHR;
      nbg_pkg::ST_U_SHR:   if (sh_r[63:32] == '0) state_nxt = nbg_pkg::ST_V_LD;
      nbg_pkg::ST_V_LD:    state_nxt = nbg_pkg::ST_V_SHR;
      nbg_pkg::ST_V_SHR:   if (sh_r[63:32] == '0) state_nxt = nbg_pkg::ST_AX_GO;
      nbg_pkg::ST_AX_GO:   state_nxt = nbg_pkg::ST_AX_WT;
      nbg_pkg::ST_AX_WT:   if (mul_rsp.done) state_nxt = nbg_pkg::ST_AX_ACC;
      nbg_pkg::ST_AX_ACC:
        state_nxt = (axis_r == 2'd2) ? nbg_pkg::ST_SRC_CHK : nbg_pkg::ST_V_LD;
      nbg_pkg::ST_EMIT: begin
        if (out_free) state_nxt = last_tgt ? nbg_pkg::ST_IDLE : nbg_pkg::ST_TGT_RD;
      end
      default: state_nxt = nbg_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    job_pop       = 1'b0;
    pass_done     = 1'b0;
    rd_addr       = j_r[IDX_W-1:0];
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    case (state_r)
      nbg_pkg::ST_IDLE:   job_pop = job_valid;
      nbg_pkg::ST_TGT_RD: rd_addr = i_r[IDX_W-1:0];
      nbg_pkg::ST_SQ_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = nbg_pkg::MUL_W'(dmag);
        mul_req.b     = nbg_pkg::MUL_W'(dmag);
      end
      nbg_pkg::ST_Q2_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {32'd0, q_r};
        mul_req.b     = {32'd0, q_r};
      end
      nbg_pkg::ST_Q3_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {32'd0, q2_r};
        mul_req.b     = {32'd0, q_r};
      end
      nbg_pkg::ST_GM_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {32'd0, grav};
        mul_req.b     = {32'd0, m_r};
      end
      nbg_pkg::ST_PQ_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {32'd0, sh_r[31:0]};
        mul_req.b     = {32'd0, q3_r};
      end
      nbg_pkg::ST_AX_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {32'd0, sh_r[31:0]};
        mul_req.b     = {32'd0, sm_r};
      end
      nbg_pkg::ST_EMIT:   pass_done = out_free && last_tgt;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= nbg_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == nbg_pkg::ST_EMIT && out_free) out_valid <= 1'b1;
      else if (!out_stall)                         out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      nbg_pkg::ST_IDLE: begin
        n_r    <= job_n;
        i_r    <= '0;
        eps2_r <= soft_len * soft_len;
      end
      nbg_pkg::ST_TGT_CAP: begin
        tx_r     <= rd_x;
        ty_r     <= rd_y;
        tz_r     <= rd_z;
        acc_r[0] <= '0;
        acc_r[1] <= '0;
        acc_r[2] <= '0;
        j_r      <= '0;
      end
      nbg_pkg::ST_SRC_CHK: if (j_r == i_r) j_r <= j_r + CNT_W'(1);
      nbg_pkg::ST_SRC_CAP: begin
        d_r[0] <= $signed({rd_x[COORD_BITS-1], rd_x}) - $signed({tx_r[COORD_BITS-1], tx_r});
        d_r[1] <= $signed({rd_y[COORD_BITS-1], rd_y}) - $signed({ty_r[COORD_BITS-1], ty_r});
        d_r[2] <= $signed({rd_z[COORD_BITS-1], rd_z}) - $signed({tz_r[COORD_BITS-1], tz_r});
        m_r    <= rd_m;
        axis_r <= 2'd0;
        r2_r   <= '0;
      end
      nbg_pkg::ST_SQ_WT: begin
        if (mul_rsp.done) begin
          r2_r <= r2_r + mul_rsp.prod;
          if (axis_r != 2'd2) axis_r <= axis_r + 2'd1;
        end
      end
      nbg_pkg::ST_SQ_EPS: begin
        r2_r <= r2_r + {80'd0, eps2_r, 16'd0};
        k_r  <= '0;
      end
      nbg_pkg::ST_NORM: begin
        // even-sized steps until the value sits in [2^60, 2^62)
        if (r2_zero) begin
          j_r <= j_r + CNT_W'(1);
        end else if (r2_r[127:94] != '0) begin
          r2_r <= r2_r >> 32;
          k_r  <= k_r + 8'sd32;
        end else if (r2_r[127:62] != '0) begin
          r2_r <= r2_r >> 2;
          k_r  <= k_r + 8'sd2;
        end else if (r2_r[127:28] == '0) begin
          r2_r <= r2_r << 32;
          k_r  <= k_r - 8'sd32;
        end else if (r2_r[61:60] == 2'b00) begin
          r2_r <= r2_r << 2;
          k_r  <= k_r - 8'sd2;
        end else begin
          sq_n_r   <= r2_r[63:0];
          sq_res_r <= '0;
          sq_bit_r <= 64'h1000_0000_0000_0000;
        end
      end
      nbg_pkg::ST_SQRT: begin
        if (sq_bit_r != '0) begin
          if (sq_n_r >= sq_try) begin
            sq_n_r   <= sq_n_r - sq_try;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
        end else begin
          rem_r     <= '0;
          q_r       <= '0;
          div_cnt_r <= '0;
        end
      end
      nbg_pkg::ST_DIV: begin
        // dividend is 2^62-1: every brought-down bit is a one
        if (rem_sh >= {1'b0, root}) begin
          rem_r <= 32'(rem_sh - {1'b0, root});
          q_r   <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh[31:0];
          q_r   <= {q_r[30:0], 1'b0};
        end
        div_cnt_r <= div_cnt_r + 6'd1;
      end
      nbg_pkg::ST_Q2_WT: if (mul_rsp.done) q2_r <= mul_rsp.prod[63:32];
      nbg_pkg::ST_Q3_WT: if (mul_rsp.done) q3_r <= mul_rsp.prod[63:32];
      nbg_pkg::ST_GM_WT, nbg_pkg::ST_PQ_WT: begin
        if (mul_rsp.done) begin
          sh_r     <= mul_rsp.prod[63:0];
          sh_cnt_r <= '0;
        end
      end
      nbg_pkg::ST_T_SHR, nbg_pkg::ST_U_SHR, nbg_pkg::ST_V_SHR: begin
        if (sh_r[63:32] != '0) begin
          sh_r     <= sh_r >> 1;
          sh_cnt_r <= sh_cnt_r + 6'd1;
        end else if (state_r == nbg_pkg::ST_T_SHR) begin
          t_r <= sh_cnt_r;
        end else if (state_r == nbg_pkg::ST_U_SHR) begin
          sm_r   <= sh_r[31:0];
          e_r    <= e_nxt;
          axis_r <= 2'd0;
        end
      end
      nbg_pkg::ST_V_LD: begin
        sh_r     <= 64'(dmag);
        sh_cnt_r <= '0;
      end
      nbg_pkg::ST_AX_WT: if (mul_rsp.done) term_r <= term_nxt;
      nbg_pkg::ST_AX_ACC: begin
        acc_r[axis_r] <= sum_sat;
        if (axis_r == 2'd2) j_r <= j_r + CNT_W'(1);
        else                axis_r <= axis_r + 2'd1;
      end
      nbg_pkg::ST_EMIT: begin
        if (out_free) begin
          out_acc_x       <= acc_r[0];
          out_acc_y       <= acc_r[1];
          out_acc_z       <= acc_r[2];
          out_body_index  <= nbg_pkg::IDX_OUT_W'(i_r);
          out_last_result <= last_tgt;
          i_r             <= i_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule
